// File: sv/tor_pkg.sv
// ----------------------------------------------------------------------------
// tor_pkg
// Shared types, constants and helpers of the time ordered event relay.
// ----------------------------------------------------------------------------
`default_nettype none

package tor_pkg;

    localparam int CAPACITY = 64;
    localparam int CLIENTS  = 8;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CL_W     = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;

    localparam logic [15:0] GRACE_RESET = 16'd3277;

    localparam logic [2:0] K_INSERT     = 3'd0;
    localparam logic [2:0] K_SET_TIME   = 3'd1;
    localparam logic [2:0] K_FETCH      = 3'd2;
    localparam logic [2:0] K_CONNECT    = 3'd3;
    localparam logic [2:0] K_DISCONNECT = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  client;
        logic [31:0] stamp;
        logic [31:0] payload;
    } in_item_t;

    typedef struct packed {
        logic        has_event;
        logic [31:0] out_stamp;
        logic [2:0]  out_client;
        logic [31:0] out_payload;
        logic [31:0] watermark;
        logic        status;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [31:0] stamp;
        logic [2:0]  owner;
        logic [31:0] payload;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APPLY,
        ST_SWEEP,
        ST_INS_RD,
        ST_INS_CHK,
        ST_INS_PUT,
        ST_DROP_RD,
        ST_DROP_CHK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        CL_NONE,
        CL_SET_TIME,
        CL_CONNECT,
        CL_DISCONNECT,
        CL_SET_MARK
    } cl_op_t;

    typedef struct packed {
        cl_op_t      op;
        logic [2:0]  client;
        logic [31:0] value;
        logic        sweep;
    } cl_cmd_t;

    typedef struct packed {
        logic        done;
        logic [31:0] wm;
        logic [31:0] mark;
    } cl_stat_t;

    // Physical slot of logical position k behind the head of the ring.
    function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] h,
                                                  logic [CNT_W-1:0] k);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(h) + (CNT_W + 1)'(k);
        if (s >= (CNT_W + 1)'(CAPACITY))
            s = s - (CNT_W + 1)'(CAPACITY);
        return s[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/tor_ram.sv
// ----------------------------------------------------------------------------
// tor_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tor_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 67
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/tor_clients.sv
// ----------------------------------------------------------------------------
// tor_clients
// Per-client local times, delivered marks and connection mask, with a
// sweep that finds both minima over connected clients, one client a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tor_clients (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tor_pkg::cl_cmd_t cmd,
    output tor_pkg::cl_stat_t     stat
);

    logic [31:0]               local_reg [tor_pkg::CLIENTS];
    logic [31:0]               mark_reg  [tor_pkg::CLIENTS];
    logic [tor_pkg::CLIENTS-1:0] mask_reg;
    logic [tor_pkg::CL_W-1:0]  idx_reg;
    logic                      active_reg;
    logic                      any_reg;
    logic                      done_reg;
    logic [31:0]               wm_reg;
    logic [31:0]               mk_reg;

    logic                      in_range;
    logic [tor_pkg::CL_W-1:0]  sel;

    assign in_range = {1'b0, cmd.client} < 4'(tor_pkg::CLIENTS);
    assign sel      = cmd.client[tor_pkg::CL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < tor_pkg::CLIENTS; c++)
            begin
                local_reg[c] <= '0;
                mark_reg[c]  <= '0;
            end
            mask_reg <= '0;
        end
        else if (in_range)
        begin
            case (cmd.op)
                tor_pkg::CL_SET_TIME:   local_reg[sel] <= cmd.value;
                tor_pkg::CL_SET_MARK:   mark_reg[sel]  <= cmd.value;
                tor_pkg::CL_CONNECT:    mask_reg[sel]  <= 1'b1;
                tor_pkg::CL_DISCONNECT: mask_reg[sel]  <= 1'b0;
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            active_reg <= 1'b0;
            any_reg    <= 1'b0;
            done_reg   <= 1'b0;
            wm_reg     <= '0;
            mk_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.sweep)
            begin
                idx_reg    <= '0;
                active_reg <= 1'b1;
                any_reg    <= 1'b0;
                wm_reg     <= '0;
                mk_reg     <= '0;
            end
            else if (active_reg)
            begin
                if (mask_reg[idx_reg])
                begin
                    if (!any_reg || local_reg[idx_reg] < wm_reg)
                    begin
                        wm_reg <= local_reg[idx_reg];
                    end
                    if (!any_reg || mark_reg[idx_reg] < mk_reg)
                    begin
                        mk_reg <= mark_reg[idx_reg];
                    end
                    any_reg <= 1'b1;
                end
                if (idx_reg == tor_pkg::CL_W'(tor_pkg::CLIENTS - 1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
                else
                begin
                    idx_reg <= idx_reg + tor_pkg::CL_W'(1);
                end
            end
        end
    end

    assign stat.done = done_reg;
    assign stat.wm   = wm_reg;
    assign stat.mark = mk_reg;

endmodule

`default_nettype wire

// File: sv/time_ordered_event_relay.sv
// ----------------------------------------------------------------------------
// time_ordered_event_relay
// Timestamp-sorted event ring in one RAM, relayed to clients on fetch with
// a watermark taken over the connected clients.
// ----------------------------------------------------------------------------
// Plain item: an apply step, then a sweep over the client tables, then a registered result.
// Insert reads and shifts up each stored entry later than the new one, then places it
// at the head or reads the earlier entry and places it behind that one.
// Fetch reads and discards head entries below the bound, then reads and scans the rest.
// One item at a time; results are strobed one cycle each, receiver cannot stall.
// Reset clears the fill count, client tables and mask; the RAM is not cleared.
`default_nettype none

module time_ordered_event_relay (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire tor_pkg::in_item_t  request,
    output tor_pkg::out_item_t      result,
    output logic                    result_valid,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [15:0]        cfg_data
);

    tor_pkg::state_t             state_reg, state_next;
    tor_pkg::in_item_t           item_reg, item_next;
    logic [tor_pkg::IDX_W-1:0]   head_reg, head_next;
    logic [tor_pkg::CNT_W-1:0]   fill_reg, fill_next;
    logic [tor_pkg::CNT_W-1:0]   k_reg, k_next;
    tor_pkg::entry_t             pend_reg, pend_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic [31:0]                 wm_reg, wm_next;
    logic [31:0]                 bound_reg, bound_next;
    logic [15:0]                 grace_reg;
    tor_pkg::out_item_t          out_reg, out_next;
    logic                        strobe_reg, strobe_next;

    logic                        ram_we, ram_re;
    logic [tor_pkg::IDX_W-1:0]   ram_waddr, ram_raddr;
    tor_pkg::entry_t             ram_wdata, rd;
    tor_pkg::cl_cmd_t            cl_cmd;
    tor_pkg::cl_stat_t           cl_stat;
    tor_pkg::entry_t             new_entry;

    assign new_entry.stamp   = item_reg.stamp;
    assign new_entry.owner   = item_reg.client;
    assign new_entry.payload = item_reg.payload;

    tor_ram #(
        .DEPTH (tor_pkg::CAPACITY),
        .WIDTH ($bits(tor_pkg::entry_t))
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd)
    );

    tor_clients u_clients (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cl_cmd),
        .stat  (cl_stat)
    );

    assign cfg_ready    = 1'b1;
    assign busy         = (state_reg != tor_pkg::ST_IDLE);
    assign result       = out_reg;
    assign result_valid = strobe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grace_reg <= tor_pkg::GRACE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            grace_reg <= cfg_data;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tor_pkg::ST_IDLE:
                if (start) state_next = tor_pkg::ST_APPLY;
            tor_pkg::ST_APPLY:
                state_next = tor_pkg::ST_SWEEP;
            tor_pkg::ST_SWEEP:
                if (cl_stat.done)
                begin
                    if (item_reg.kind == tor_pkg::K_INSERT)
                    begin
                        if (fill_reg == tor_pkg::CNT_W'(tor_pkg::CAPACITY))
                            state_next = tor_pkg::ST_IDLE;
                        else if (fill_reg == '0)
                            state_next = tor_pkg::ST_INS_PUT;
                        else
                            state_next = tor_pkg::ST_INS_RD;
                    end
                    else if (item_reg.kind == tor_pkg::K_FETCH)
                        state_next = tor_pkg::ST_DROP_RD;
                    else
                        state_next = tor_pkg::ST_IDLE;
                end
            tor_pkg::ST_INS_RD:
                state_next = tor_pkg::ST_INS_CHK;
            tor_pkg::ST_INS_CHK:
                if (item_reg.stamp < rd.stamp)
                    state_next = (k_reg == tor_pkg::CNT_W'(1)) ? tor_pkg::ST_INS_PUT
                                                                : tor_pkg::ST_INS_RD;
                else
                    state_next = tor_pkg::ST_IDLE;
            tor_pkg::ST_INS_PUT:
                state_next = tor_pkg::ST_IDLE;
            tor_pkg::ST_DROP_RD:
                state_next = (fill_reg == '0) ? tor_pkg::ST_SCAN_RD : tor_pkg::ST_DROP_CHK;
            tor_pkg::ST_DROP_CHK:
                state_next = (rd.stamp < bound_reg) ? tor_pkg::ST_DROP_RD
                                                    : tor_pkg::ST_SCAN_RD;
            tor_pkg::ST_SCAN_RD:
                state_next = (k_reg == fill_reg) ? tor_pkg::ST_FINISH : tor_pkg::ST_SCAN_CHK;
            tor_pkg::ST_SCAN_CHK:
                if (rd.stamp > item_reg.stamp && rd.stamp > wm_reg)
                    state_next = tor_pkg::ST_FINISH;
                else
                    state_next = tor_pkg::ST_SCAN_RD;
            tor_pkg::ST_FINISH:
                state_next = tor_pkg::ST_IDLE;
            default:
                state_next = tor_pkg::ST_IDLE;
        endcase
    end

    // Datapath, RAM and client table controls
    always_comb
    begin
        item_next       = item_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        k_next          = k_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        wm_next         = wm_reg;
        bound_next      = bound_reg;
        out_next        = out_reg;
        strobe_next     = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = tor_pkg::wrap_add(head_reg, k_reg);
        ram_raddr       = tor_pkg::wrap_add(head_reg, k_reg);
        ram_wdata       = new_entry;
        cl_cmd.op       = tor_pkg::CL_NONE;
        cl_cmd.client   = item_reg.client;
        cl_cmd.value    = item_reg.stamp;
        cl_cmd.sweep    = 1'b0;

        // Plain result, overridden where an event is delivered or an insert is refused
        out_next.has_event   = 1'b0;
        out_next.out_stamp   = '0;
        out_next.out_client  = '0;
        out_next.out_payload = '0;
        out_next.watermark   = wm_reg;
        out_next.status      = 1'b0;
        out_next.last        = 1'b1;

        case (state_reg)
            tor_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    item_next = request;
                end
            end
            tor_pkg::ST_APPLY:
            begin
                cl_cmd.sweep = 1'b1;
                case (item_reg.kind)
                    tor_pkg::K_SET_TIME:   cl_cmd.op = tor_pkg::CL_SET_TIME;
                    tor_pkg::K_CONNECT:    cl_cmd.op = tor_pkg::CL_CONNECT;
                    tor_pkg::K_DISCONNECT: cl_cmd.op = tor_pkg::CL_DISCONNECT;
                    default:               cl_cmd.op = tor_pkg::CL_NONE;
                endcase
            end
            tor_pkg::ST_SWEEP:
            begin
                if (cl_stat.done)
                begin
                    wm_next            = cl_stat.wm;
                    out_next.watermark = cl_stat.wm;
                    bound_next = (cl_stat.mark >= {16'd0, grace_reg})
                               ? cl_stat.mark - {16'd0, grace_reg} : '0;
                    k_next          = fill_reg;
                    pend_valid_next = 1'b0;
                    if (item_reg.kind == tor_pkg::K_INSERT)
                    begin
                        if (fill_reg == tor_pkg::CNT_W'(tor_pkg::CAPACITY))
                        begin
                            out_next.status = 1'b1;
                            strobe_next     = 1'b1;
                        end
                    end
                    else if (item_reg.kind == tor_pkg::K_FETCH)
                    begin
                        k_next = '0;
                    end
                    else
                    begin
                        strobe_next = 1'b1;
                    end
                end
            end
            tor_pkg::ST_INS_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = tor_pkg::wrap_add(head_reg, k_reg - tor_pkg::CNT_W'(1));
            end
            tor_pkg::ST_INS_CHK:
            begin
                ram_we = 1'b1;
                if (item_reg.stamp < rd.stamp)
                begin
                    // Shift the later entry up one slot
                    ram_wdata = rd;
                    k_next    = k_reg - tor_pkg::CNT_W'(1);
                end
                else
                begin
                    fill_next   = fill_reg + tor_pkg::CNT_W'(1);
                    strobe_next = 1'b1;
                end
            end
            tor_pkg::ST_INS_PUT:
            begin
                ram_we      = 1'b1;
                fill_next   = fill_reg + tor_pkg::CNT_W'(1);
                strobe_next = 1'b1;
            end
            tor_pkg::ST_DROP_RD:
            begin
                ram_re    = (fill_reg != '0);
                ram_raddr = head_reg;
            end
            tor_pkg::ST_DROP_CHK:
            begin
                if (rd.stamp < bound_reg)
                begin
                    head_next = tor_pkg::wrap_add(head_reg, tor_pkg::CNT_W'(1));
                    fill_next = fill_reg - tor_pkg::CNT_W'(1);
                end
            end
            tor_pkg::ST_SCAN_RD:
            begin
                ram_re = (k_reg != fill_reg);
            end
            tor_pkg::ST_SCAN_CHK:
            begin
                k_next = k_reg + tor_pkg::CNT_W'(1);
                if (rd.stamp > item_reg.stamp && rd.stamp <= wm_reg &&
                    rd.owner != item_reg.client)
                begin
                    // Hold the newest hit; release the previous one as not last
                    if (pend_valid_reg)
                    begin
                        out_next.has_event   = 1'b1;
                        out_next.out_stamp   = pend_reg.stamp;
                        out_next.out_client  = pend_reg.owner;
                        out_next.out_payload = pend_reg.payload;
                        out_next.last        = 1'b0;
                        strobe_next          = 1'b1;
                    end
                    pend_next       = rd;
                    pend_valid_next = 1'b1;
                end
            end
            tor_pkg::ST_FINISH:
            begin
                cl_cmd.op    = tor_pkg::CL_SET_MARK;
                cl_cmd.value = wm_reg;
                strobe_next  = 1'b1;
                if (pend_valid_reg)
                begin
                    out_next.has_event   = 1'b1;
                    out_next.out_stamp   = pend_reg.stamp;
                    out_next.out_client  = pend_reg.owner;
                    out_next.out_payload = pend_reg.payload;
                end
                pend_valid_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        if (!strobe_next)
        begin
            out_next = out_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tor_pkg::ST_IDLE;
            head_reg       <= '0;
            fill_reg       <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        k_reg     <= k_next;
        pend_reg  <= pend_next;
        wm_reg    <= wm_next;
        bound_reg <= bound_next;
        out_reg   <= out_next;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= tor_pkg::CNT_W'(tor_pkg::CAPACITY))
        else $error("fill count beyond capacity");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_plain_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.has_event) |-> result.last)
        else $error("result without event not marked last");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |-> !busy)
        else $error("final result while still busy");

endmodule

`default_nettype wire

// File: verif/time_ordered_event_relay_test.sv
// ----------------------------------------------------------------------------
// time_ordered_event_relay_test
// Self-checking bench for the time ordered event relay. A queue of pending
// steps (items, grace margin writes, drain points) feeds a clocked driver that
// idles at random. A built-in model of the sorted store and the client tables
// predicts every result, and a clocked monitor checks each strobed result
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module time_ordered_event_relay_test;

    localparam logic [2:0] K_SPARE_5 = 3'd5;
    localparam logic [2:0] K_SPARE_6 = 3'd6;
    localparam logic [2:0] K_SPARE_7 = 3'd7;
    localparam int SETTLE_CYCLES = 16;

    typedef enum logic [1:0] { STEP_ITEM, STEP_GRACE, STEP_DRAIN } step_op_t;

    typedef struct {
        step_op_t            op;
        tor_pkg::in_item_t   item;
        logic [15:0]         grace;
    } step_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    tor_pkg::in_item_t   request = '0;
    tor_pkg::out_item_t  result;
    logic                result_valid;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [15:0]         cfg_data = '0;

    time_ordered_event_relay u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result       (result),
        .result_valid (result_valid),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // Model of the relay state
    logic [31:0] ev_stamp [tor_pkg::CAPACITY];
    logic [2:0]  ev_owner [tor_pkg::CAPACITY];
    logic [31:0] ev_payload [tor_pkg::CAPACITY];
    int          ev_fill;
    logic [31:0] local_time [tor_pkg::CLIENTS];
    logic [31:0] dlv_mark [tor_pkg::CLIENTS];
    logic [7:0]  conn_mask;
    logic [15:0] grace_margin;

    step_t               pending_steps[$];
    tor_pkg::out_item_t  due_results[$];
    bit                  failed;
    int                  gap_left;
    int                  quiet;

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] min_connected(bit use_marks);
        logic [31:0] m;
        bit          any;
        m = '0;
        any = 0;
        for (int c = 0; c < tor_pkg::CLIENTS; c++)
        begin
            if (conn_mask[c])
            begin
                if (!any || (use_marks ? dlv_mark[c] : local_time[c]) < m)
                    m = use_marks ? dlv_mark[c] : local_time[c];
                any = 1;
            end
        end
        return m;
    endfunction

    function automatic void predict_relay(tor_pkg::in_item_t r);
        tor_pkg::out_item_t o;
        logic [31:0] wm;
        logic [31:0] mark;
        logic [31:0] bound;
        logic        dropped;
        int          pos;
        int          drop;
        int          n;
        dropped = 1'b0;
        n = 0;
        case (r.kind)
            tor_pkg::K_INSERT:
            begin
                if (ev_fill >= tor_pkg::CAPACITY)
                    dropped = 1'b1;
                else
                begin
                    pos = ev_fill;
                    for (int i = 0; i < ev_fill; i++)
                    begin
                        if (r.stamp < ev_stamp[i])
                        begin
                            pos = i;
                            break;
                        end
                    end
                    for (int i = ev_fill; i > pos; i--)
                    begin
                        ev_stamp[i] = ev_stamp[i-1];
                        ev_owner[i] = ev_owner[i-1];
                        ev_payload[i] = ev_payload[i-1];
                    end
                    ev_stamp[pos] = r.stamp;
                    ev_owner[pos] = r.client;
                    ev_payload[pos] = r.payload;
                    ev_fill++;
                end
            end
            tor_pkg::K_SET_TIME:   local_time[r.client] = r.stamp;
            tor_pkg::K_CONNECT:    conn_mask[r.client] = 1'b1;
            tor_pkg::K_DISCONNECT: conn_mask[r.client] = 1'b0;
            tor_pkg::K_FETCH:
            begin
                wm = min_connected(0);
                mark = min_connected(1);
                bound = (mark >= {16'd0, grace_margin}) ? mark - {16'd0, grace_margin}
                                                        : 32'd0;
                drop = 0;
                while (drop < ev_fill && ev_stamp[drop] < bound)
                    drop++;
                for (int i = drop; i < ev_fill; i++)
                begin
                    ev_stamp[i-drop] = ev_stamp[i];
                    ev_owner[i-drop] = ev_owner[i];
                    ev_payload[i-drop] = ev_payload[i];
                end
                ev_fill -= drop;
                for (int i = 0; i < ev_fill; i++)
                begin
                    if (ev_stamp[i] <= r.stamp)
                        continue;
                    if (ev_stamp[i] > wm)
                        break;
                    if (ev_owner[i] != r.client)
                    begin
                        o = '{1'b1, ev_stamp[i], ev_owner[i], ev_payload[i], wm, 1'b0, 1'b0};
                        due_results.insert(due_results.size(), o);
                        n++;
                    end
                end
                dlv_mark[r.client] = wm;
                if (n > 0)
                    due_results[due_results.size() - 1].last = 1'b1;
            end
            default: ;
        endcase
        if (n == 0)
        begin
            o = '{1'b0, 32'd0, 3'd0, 32'd0, min_connected(0), dropped, 1'b1};
            due_results.insert(due_results.size(), o);
        end
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 94)
            return $urandom_range(1, 4);
        return $urandom_range(20, 90);
    endfunction

    // Driver: present items, grace writes, and hold at drain points
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || (cfg_valid && cfg_ready))
            begin
                if (start && !busy)
                    predict_relay(request);
                else
                    grace_margin = cfg_data;
                pending_steps.delete(0);
                gap_left = pick_gap();
            end
            if (due_results.size() == 0 && !busy && !start)
                quiet++;
            else
                quiet = 0;
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
                cfg_valid <= 1'b0;
            end
            else if (pending_steps.size() > 0 && pending_steps[0].op == STEP_ITEM)
            begin
                start <= 1'b1;
                request <= pending_steps[0].item;
                cfg_valid <= 1'b0;
            end
            else if (pending_steps.size() > 0 && pending_steps[0].op == STEP_GRACE)
            begin
                start <= 1'b0;
                cfg_valid <= (quiet >= SETTLE_CYCLES);
                cfg_data <= pending_steps[0].grace;
            end
            else
            begin
                start <= 1'b0;
                cfg_valid <= 1'b0;
                if (pending_steps.size() > 0 && quiet >= SETTLE_CYCLES)
                    pending_steps.delete(0);
            end
        end
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            failed = 1;
        end
    endtask

    // Monitor: every strobed result is one transaction
    always @(posedge clk)
    begin
        tor_pkg::out_item_t exp_r;
        if (rst_n && result_valid)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                failed = 1;
            end
            else
            begin
                exp_r = due_results[0];
                due_results.delete(0);
                check_field("has_event", 32'(exp_r.has_event), 32'(result.has_event));
                check_field("out_stamp", exp_r.out_stamp, result.out_stamp);
                check_field("out_client", 32'(exp_r.out_client), 32'(result.out_client));
                check_field("out_payload", exp_r.out_payload, result.out_payload);
                check_field("watermark", exp_r.watermark, result.watermark);
                check_field("status", 32'(exp_r.status), 32'(result.status));
                check_field("last", 32'(exp_r.last), 32'(result.last));
            end
        end
    end

    task automatic add_item(logic [2:0] kind, logic [2:0] client,
                            logic [31:0] stamp, logic [31:0] payload);
        step_t s;
        s.op = STEP_ITEM;
        s.item = '{kind, client, stamp, payload};
        s.grace = '0;
        pending_steps.insert(pending_steps.size(), s);
    endtask

    task automatic add_grace(logic [15:0] g);
        step_t s;
        s.op = STEP_GRACE;
        s.item = '0;
        s.grace = g;
        pending_steps.insert(pending_steps.size(), s);
    endtask

    task automatic add_drain();
        step_t s;
        s.op = STEP_DRAIN;
        s.item = '0;
        s.grace = '0;
        pending_steps.insert(pending_steps.size(), s);
    endtask

    initial
    begin
        logic [31:0] now;
        int          roll;
        failed = 0;
        gap_left = 0;
        quiet = 0;
        ev_fill = 0;
        conn_mask = '0;
        grace_margin = tor_pkg::GRACE_RESET;
        for (int c = 0; c < tor_pkg::CLIENTS; c++)
        begin
            local_time[c] = '0;
            dlv_mark[c] = '0;
        end
        for (int i = 0; i < tor_pkg::CAPACITY; i++)
        begin
            ev_stamp[i] = '0;
            ev_owner[i] = '0;
            ev_payload[i] = '0;
        end

        // Directed: extremes, equal stamps, no client connected, spare kinds
        add_item(tor_pkg::K_FETCH, 3'd0, 32'd0, 32'd0);
        add_item(tor_pkg::K_INSERT, 3'd0, 32'd0, 32'd0);
        add_item(tor_pkg::K_INSERT, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(tor_pkg::K_INSERT, 3'd3, 32'd0, 32'h1234_5678);
        add_item(tor_pkg::K_INSERT, 3'd5, 32'h0001_0000, 32'hA5A5_5A5A);
        add_item(tor_pkg::K_SET_TIME, 3'd7, 32'hFFFF_FFFF, 32'd0);
        add_item(tor_pkg::K_CONNECT, 3'd7, 32'd0, 32'd0);
        add_item(tor_pkg::K_CONNECT, 3'd7, 32'd0, 32'd0);
        add_item(tor_pkg::K_CONNECT, 3'd0, 32'd0, 32'd0);
        add_item(tor_pkg::K_SET_TIME, 3'd0, 32'h0002_0000, 32'd0);
        add_item(tor_pkg::K_FETCH, 3'd3, 32'd0, 32'd0);
        add_item(tor_pkg::K_FETCH, 3'd0, 32'd0, 32'd0);
        add_item(tor_pkg::K_FETCH, 3'd7, 32'd0, 32'd0);
        add_item(tor_pkg::K_DISCONNECT, 3'd0, 32'd0, 32'd0);
        add_item(tor_pkg::K_DISCONNECT, 3'd0, 32'd0, 32'd0);
        add_item(tor_pkg::K_FETCH, 3'd7, 32'hFFFF_FFFE, 32'd0);
        add_item(K_SPARE_5, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(K_SPARE_6, 3'd2, 32'h0F0F_0F0F, 32'h0);
        add_item(K_SPARE_7, 3'd4, 32'h0, 32'hFFFF_FFFF);
        add_item(tor_pkg::K_DISCONNECT, 3'd7, 32'd0, 32'd0);
        add_drain();

        // Fill past capacity, deliver a full store, then discard it all
        add_grace(16'd0);
        for (int i = 0; i < tor_pkg::CAPACITY + 2; i++)
            add_item(tor_pkg::K_INSERT, 3'($urandom_range(0, 7)),
                     $urandom_range(1, 200000), $urandom);
        add_item(tor_pkg::K_CONNECT, 3'd1, 32'd0, 32'd0);
        add_item(tor_pkg::K_SET_TIME, 3'd1, 32'hFFFF_FFFF, 32'd0);
        add_item(tor_pkg::K_FETCH, 3'd2, 32'd0, 32'd0);
        add_item(tor_pkg::K_FETCH, 3'd1, 32'd0, 32'd0);
        add_item(tor_pkg::K_FETCH, 3'd1, 32'd0, 32'd0);
        add_item(tor_pkg::K_DISCONNECT, 3'd1, 32'd0, 32'd0);
        add_drain();

        // Random rounds, each under its own grace margin
        now = 32'd1000;
        for (int round = 0; round < 6; round++)
        begin
            case (round)
                0: add_grace(16'hFFFF);
                1: add_grace(tor_pkg::GRACE_RESET);
                2: add_grace(16'd0);
                default: add_grace(16'($urandom));
            endcase
            for (int c = 0; c < 4; c++)
                add_item(tor_pkg::K_CONNECT, 3'($urandom_range(0, 7)), 32'd0, 32'd0);
            for (int n = 0; n < 22; n++)
            begin
                now += $urandom_range(0, 6000);
                roll = $urandom_range(0, 99);
                if (roll < 42)
                    add_item(tor_pkg::K_INSERT, 3'($urandom_range(0, 7)),
                             ($urandom_range(0, 9) == 0) ? $urandom : now + $urandom_range(0, 40000),
                             $urandom);
                else if (roll < 62)
                    add_item(tor_pkg::K_SET_TIME, 3'($urandom_range(0, 7)),
                             ($urandom_range(0, 9) == 0) ? $urandom : now + $urandom_range(0, 30000),
                             $urandom);
                else if (roll < 84)
                    add_item(tor_pkg::K_FETCH, 3'($urandom_range(0, 7)),
                             ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000)
                                                         : now - $urandom_range(0, 60000),
                             $urandom);
                else if (roll < 90)
                    add_item(tor_pkg::K_CONNECT, 3'($urandom_range(0, 7)), $urandom, $urandom);
                else if (roll < 96)
                    add_item(tor_pkg::K_DISCONNECT, 3'($urandom_range(0, 7)),
                             $urandom, $urandom);
                else
                    add_item(3'($urandom_range(5, 7)), 3'($urandom_range(0, 7)),
                             $urandom, $urandom);
                if (n == 11)
                    add_drain();
            end
            add_drain();
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_steps.size() > 0 || due_results.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (!failed && due_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
sv/tor_pkg.sv
sv/tor_ram.sv
sv/tor_clients.sv
sv/time_ordered_event_relay.sv
verif/time_ordered_event_relay_test.sv
